// File: rtl/core/acpd_pkg.sv
// Shared types and constants for the autocorrelation pitch detector.
// Used by acpd_divider and autocorrelation_pitch_detector; no dependencies.
package acpd_pkg;

  localparam int unsigned MaxSamples  = 1024;
  localparam int unsigned AddrW       = $clog2(MaxSamples);
  localparam int unsigned CountW      = AddrW + 1;
  localparam int unsigned SampleW     = 16;
  localparam int unsigned RateW       = 18;
  localparam int unsigned LimitW      = 15;
  localparam int unsigned FreqW       = 22;
  localparam int unsigned MaxHarmonic = 5;
  localparam int unsigned HarmW       = $clog2(MaxHarmonic + 1);
  localparam int unsigned AccW        = 2 * SampleW + CountW;
  // Divisor is period * harmonic.
  localparam int unsigned DivW        = AddrW + HarmW;
  // Dividend is rate * 32 + divisor.
  localparam int unsigned NumW        = RateW + 6;

  // Configuration register indexes.
  localparam logic [0:0] RegSampleRate = 1'b0;
  localparam logic [0:0] RegHarmLimit  = 1'b1;

  // Controller states, one-hot.
  typedef enum logic [7:0] {
    StLoad  = 8'b0000_0001,
    StMac   = 8'b0000_0010,
    StDrain = 8'b0000_0100,
    StPeak  = 8'b0000_1000,
    StHarm  = 8'b0001_0000,
    StDiv   = 8'b0010_0000,
    StWait  = 8'b0100_0000,
    StOut   = 8'b1000_0000
  } state_e;

  // Request from the controller to the divider.
  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [DivW-1:0] den;
  } div_req_t;

  // Divider status returned to the controller.
  typedef struct packed {
    logic            busy;
    logic [NumW-1:0] quot;
  } div_rsp_t;

endpackage

// File: rtl/core/acpd_divider.sv
// Restoring divider, one quotient bit per cycle, for the frequency result.
// Depends on acpd_pkg.
module acpd_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  acpd_pkg::div_req_t req_i,
  output acpd_pkg::div_rsp_t rsp_o
);
  import acpd_pkg::*;

  localparam int unsigned StepW = $clog2(NumW + 1);

  logic [NumW-1:0]  quot_q, quot_d;
  logic [DivW:0]    rem_q, rem_d;
  logic [DivW-1:0]  den_q, den_d;
  logic [StepW-1:0] step_q, step_d;
  logic             busy_q, busy_d;
  logic [DivW:0]    trial;

  // One shift-subtract step per cycle, MSB first.
  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    step_d = step_q;
    busy_d = busy_q;
    trial  = {rem_q[DivW-1:0], quot_q[NumW-1]};
    if (req_i.start) begin
      quot_d = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
      step_d = StepW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d  = trial - {1'b0, den_q};
        quot_d = {quot_q[NumW-2:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[NumW-2:0], 1'b0};
      end
      step_d = step_q - 1'b1;
      busy_d = (step_q != StepW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.quot = quot_q;

`ifndef NO_ASSERTIONS
  // When idle the step count is zero; a start makes the divider busy.
  a_step_zero_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> step_q == '0 || $past(req_i.start)) else $error("divider step count");
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> busy_q) else $error("divider did not start");
  a_no_zero_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> req_i.den != '0) else $error("divider zero divisor");
`endif

endmodule

// File: rtl/core/autocorrelation_pitch_detector.sv
// Autocorrelation pitch detector over a 1024-entry sample memory with one registered read.
// Samples are taken one per cycle while loading; the result of a frame of n samples
// follows the last request after the reads, products and peak checks of each lag
// (two reads per product), up to 5 harmonic checks and a division.
// The next frame is accepted once the result has been taken. Reset is asynchronous,
// active low, restores the registers to 48000 Hz and 350 Hz and empties the frame.
module autocorrelation_pitch_detector (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [15:0] sample
  input  logic        s_axis_tlast,  // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [21:0] frequency_q4, [31:22] period_lag
  output logic        m_axis_tuser,  // found
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [17:0] cfg_data_i
);
  import acpd_pkg::*;

  state_e state_q, state_d;

  logic [RateW-1:0]  rate_q;
  logic [LimitW-1:0] limit_q;
  logic [CountW-1:0] count_q, count_d;  // samples in frame
  logic [AddrW-1:0]  lag_q, lag_d;
  logic [CountW-1:0] idx_q, idx_d;
  logic              rd_vld_q, rd_vld_d;  // a read was issued last cycle
  logic              rd_sel_q, rd_sel_d;  // 0: reading s[i], 1: reading s[i+lag]
  logic signed [SampleW-1:0] mem [MaxSamples];
  logic signed [SampleW-1:0] rd_q, opa_q, opa_d;
  logic signed [2*SampleW-1:0] prod_q, prod_d;
  logic              prod_vld_q, prod_vld_d;
  logic signed [AccW-1:0] acc_q, acc_d, r0_q, r0_d, prev_q, prev_d;
  logic [1:0]        phase_q, phase_d;
  logic [AddrW-1:0]  period_q, period_d;
  logic [HarmW-1:0]  harm_q, harm_d;
  logic [DivW-1:0]   den_q, den_d;
  logic [FreqW-1:0]  freq_q, freq_d;
  logic              found_q, found_d;
  logic [AddrW-1:0]  rd_addr;
  logic              mem_we;
  logic [AddrW:0]    pair_end;
  div_req_t          div_req;
  div_rsp_t          div_rsp;
  logic [LimitW+DivW-1:0] lim_prod;

  localparam logic [1:0] PhIdle = 2'd0, PhArmed = 2'd1, PhRise = 2'd2;

  // Configuration writes are taken at any time.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q  <= RateW'(48000);
      limit_q <= LimitW'(350);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegSampleRate: rate_q  <= cfg_data_i;
        RegHarmLimit:  limit_q <= cfg_data_i[LimitW-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state_q == StLoad);
  assign mem_we = s_axis_tvalid && s_axis_tready && (count_q < CountW'(MaxSamples));

  // Sample memory with one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[count_q[AddrW-1:0]] <= s_axis_tdata;
    rd_q <= mem[rd_addr];
  end

  assign rd_addr  = rd_sel_d ? AddrW'(idx_q + CountW'(lag_q)) : idx_q[AddrW-1:0];
  // MAC pairs for this lag: i runs while i + lag < n.
  assign pair_end = (AddrW+1)'(count_q) - (AddrW+1)'(lag_q);
  assign lim_prod = limit_q * den_q;

  assign div_req.start = (state_q == StDiv);
  assign div_req.num   = {rate_q, 5'd0} + NumW'(den_q);
  assign div_req.den   = den_q;

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    lag_d      = lag_q;
    idx_d      = idx_q;
    rd_vld_d   = 1'b0;
    rd_sel_d   = 1'b0;
    opa_d      = opa_q;
    prod_d     = prod_q;
    prod_vld_d = 1'b0;
    acc_d      = acc_q;
    r0_d       = r0_q;
    prev_d     = prev_q;
    phase_d    = phase_q;
    period_d   = period_q;
    harm_d     = harm_q;
    den_d      = den_q;
    freq_d     = freq_q;
    found_d    = found_q;

    // Accumulate the product registered last cycle.
    if (prod_vld_q) acc_d = acc_q + AccW'(prod_q);
    // Two reads per pair: first s[i], then s[i+lag].
    if (rd_vld_q) begin
      if (rd_sel_q) begin
        prod_d     = opa_q * rd_q;
        prod_vld_d = 1'b1;
      end else begin
        opa_d = rd_q;
      end
    end

    case (state_q)
      StLoad: begin
        if (s_axis_tvalid) begin
          if (mem_we) count_d = count_q + 1'b1;
          if (s_axis_tlast) begin
            lag_d   = '0;
            idx_d   = '0;
            acc_d   = '0;
            phase_d = PhIdle;
            state_d = StMac;
          end
        end
      end
      StMac: begin
        if (idx_q >= pair_end) begin
          state_d = StDrain;
        end else begin
          rd_vld_d = 1'b1;
          rd_sel_d = rd_vld_q && !rd_sel_q;
          if (rd_sel_d) idx_d = idx_q + 1'b1;
        end
      end
      StDrain: begin
        if (!rd_vld_q && !prod_vld_q) state_d = StPeak;
      end
      StPeak: begin
        state_d = StMac;
        idx_d   = '0;
        acc_d   = '0;
        prev_d  = acc_q;
        if (phase_q == PhRise && acc_q <= prev_q) begin
          period_d = lag_q;
          found_d  = 1'b1;
          harm_d   = HarmW'(1);
          den_d    = DivW'(lag_q);
          state_d  = StHarm;
        end else begin
          if (phase_q == PhArmed && (acc_q <<< 1) > r0_q && acc_q > prev_q) phase_d = PhRise;
          if (lag_q == '0) begin
            r0_d    = acc_q;
            phase_d = PhArmed;
          end
          if ((AddrW+1)'(lag_q) + 1'b1 >= (AddrW+1)'(count_q)) begin
            found_d  = 1'b0;
            period_d = '0;
            freq_d   = '0;
            state_d  = StOut;
          end else begin
            lag_d = lag_q + 1'b1;
          end
        end
      end
      StHarm: begin
        // Accept harmonic when rate < limit * period * h.
        if ((LimitW+DivW)'(rate_q) < lim_prod) begin
          state_d = StDiv;
        end else if (harm_q == HarmW'(MaxHarmonic)) begin
          den_d   = DivW'(period_q);
          state_d = StDiv;
        end else begin
          harm_d = harm_q + 1'b1;
          den_d  = den_q + DivW'(period_q);
        end
      end
      StDiv: begin
        state_d = StWait;
      end
      StWait: begin
        if (!div_rsp.busy) begin
          // Quotient by 2*den: drop the low bit.
          freq_d  = div_rsp.quot[FreqW:1];
          state_d = StOut;
        end
      end
      StOut: begin
        if (m_axis_tready) begin
          count_d = '0;
          state_d = StLoad;
        end
      end
      default: state_d = StLoad;
    endcase
  end

  acpd_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StLoad;
      count_q    <= '0;
      rd_vld_q   <= 1'b0;
      rd_sel_q   <= 1'b0;
      prod_vld_q <= 1'b0;
      phase_q    <= PhIdle;
      found_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      rd_vld_q   <= rd_vld_d;
      rd_sel_q   <= rd_sel_d;
      prod_vld_q <= prod_vld_d;
      phase_q    <= phase_d;
      found_q    <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lag_q    <= lag_d;
    idx_q    <= idx_d;
    opa_q    <= opa_d;
    prod_q   <= prod_d;
    acc_q    <= acc_d;
    r0_q     <= r0_d;
    prev_q   <= prev_d;
    period_q <= period_d;
    harm_q   <= harm_d;
    den_q    <= den_d;
    freq_q   <= freq_d;
  end

  assign m_axis_tvalid = (state_q == StOut);
  assign m_axis_tdata  = {period_q, freq_q};
  assign m_axis_tuser  = found_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(MaxSamples)) else $error("frame count overflow");
  a_no_found_zero_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> period_q != '0) else $error("found with zero lag");
  a_no_load_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> state_q == StLoad) else $error("sample write outside load");
  a_pipe_empty_at_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StPeak |-> !prod_vld_q && !rd_vld_q) else $error("MAC pipe not drained");
`endif

endmodule
